[hdl/bounded_deque_with_erase_top_macros.svh]
// Assertion macros shared by the deque controller and datapath.
`ifndef BOUNDED_DEQUE_WITH_ERASE_TOP_MACROS_SVH
`define BOUNDED_DEQUE_WITH_ERASE_TOP_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define BDQ_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define BDQ_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

// Check that a condition holds in the same cycle as a trigger.
`define BDQ_ASSERT_SAME(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

`endif

[hdl/bdq_pkg.sv]
// Package with types, constants and command structs of the bounded deque.
package bdq_pkg;

	localparam int DEPTH_DEF  = 256;
	localparam int DATA_W_DEF = 32;

	localparam int MODE_W   = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 9;
	localparam int STATUS_W = 2;
	localparam int CNT_W    = 9;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH_FRONT = 3'd0,
		MODE_PUSH_BACK  = 3'd1,
		MODE_POP_FRONT  = 3'd2,
		MODE_POP_BACK   = 3'd3,
		MODE_ERASE      = 3'd4,
		MODE_COUNT      = 3'd5
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_BAD_POS = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		RD_FRONT = 2'd0,
		RD_BACK  = 2'd1,
		RD_K     = 2'd2,
		RD_KNEXT = 2'd3
	} rd_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_POP_WAIT,
		S_ERASE_RD,
		S_ERASE_WR,
		S_COUNT,
		S_RD_FRONT,
		S_RD_BACK,
		S_BACK_CAP,
		S_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load;
		logic    set_status;
		status_t status_code;
		logic    ins_front;
		logic    ins_back;
		logic    take_front;
		logic    take_back;
		logic    drop_front;
		logic    dec_count;
		logic    k_from_pos;
		logic    k_clear;
		logic    erase_wr;
		logic    count_rd;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    cap_popped;
		logic    cap_front;
		logic    cap_back;
		logic    clr_ends;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		mode_t mode;
		logic  empty;
		logic  full;
		logic  pos_front;
		logic  pos_beyond;
		logic  erase_more;
		logic  count_more;
	} stat_t;

endpackage

[hdl/bdq_ctrl.sv]
// Controller state machine of the bounded deque.
`include "bounded_deque_with_erase_top_macros.svh"

module bdq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output logic           done,
	input  bdq_pkg::stat_t stat,
	output bdq_pkg::cmd_t  cmd
);
	import bdq_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		done    = 1'b0;
		accept  = 1'b0;
		unique case (state_q)
			S_IDLE, S_DONE: begin
				busy   = 1'b0;
				done   = (state_q == S_DONE);
				accept = start;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end else begin
					state_d  = S_IDLE;
				end
			end
			S_DISPATCH: begin
				state_d = S_RD_FRONT;
				unique case (stat.mode)
					MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
						if (stat.full) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = ST_FULL;
						end else if (stat.mode == MODE_PUSH_FRONT) begin
							cmd.ins_front = 1'b1;
						end else begin
							cmd.ins_back = 1'b1;
						end
					end
					MODE_POP_FRONT, MODE_POP_BACK: begin
						if (stat.empty) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = ST_EMPTY;
						end else begin
							cmd.rd_en = 1'b1;
							if (stat.mode == MODE_POP_FRONT) begin
								cmd.take_front = 1'b1;
								cmd.rd_sel     = RD_FRONT;
							end else begin
								cmd.take_back = 1'b1;
								cmd.rd_sel    = RD_BACK;
							end
							state_d = S_POP_WAIT;
						end
					end
					MODE_ERASE: begin
						if (stat.empty) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = ST_EMPTY;
						end else if (stat.pos_front) begin
							cmd.drop_front = 1'b1;
						end else if (stat.pos_beyond) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = ST_BAD_POS;
						end else begin
							cmd.k_from_pos = 1'b1;
							state_d        = S_ERASE_RD;
						end
					end
					MODE_COUNT: begin
						cmd.k_clear = 1'b1;
						state_d     = S_COUNT;
					end
					default: begin
						state_d = S_RD_FRONT;
					end
				endcase
			end
			S_POP_WAIT: begin
				cmd.cap_popped = 1'b1;
				state_d        = S_RD_FRONT;
			end
			S_ERASE_RD: begin
				if (stat.erase_more) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_KNEXT;
					state_d    = S_ERASE_WR;
				end else begin
					cmd.dec_count = 1'b1;
					state_d       = S_RD_FRONT;
				end
			end
			S_ERASE_WR: begin
				cmd.erase_wr = 1'b1;
				state_d      = S_ERASE_RD;
			end
			S_COUNT: begin
				if (stat.count_more) begin
					cmd.count_rd = 1'b1;
					cmd.rd_en    = 1'b1;
					cmd.rd_sel   = RD_K;
				end else begin
					state_d = S_RD_FRONT;
				end
			end
			S_RD_FRONT: begin
				if (stat.empty) begin
					cmd.clr_ends = 1'b1;
					state_d      = S_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_FRONT;
					state_d    = S_RD_BACK;
				end
			end
			S_RD_BACK: begin
				cmd.cap_front = 1'b1;
				cmd.rd_en     = 1'b1;
				cmd.rd_sel    = RD_BACK;
				state_d       = S_BACK_CAP;
			end
			S_BACK_CAP: begin
				cmd.cap_back = 1'b1;
				state_d      = S_DONE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	`BDQ_ASSERT_NEXT(a_done_single, done, !done, "result strobe lasted more than one cycle")
	`BDQ_ASSERT_NEXT(a_accept_busy, accept, busy && !done, "accepted beat did not start work")
	`BDQ_ASSERT_SAME(a_done_ready, done, !busy, "result strobe while busy")

endmodule

[hdl/bdq_dpath.sv]
// Datapath of the bounded deque: ring store, pointers, counters and result registers.
`include "bounded_deque_with_erase_top_macros.svh"

module bdq_dpath #(
	parameter int DEPTH  = bdq_pkg::DEPTH_DEF,
	parameter int DATA_W = bdq_pkg::DATA_W_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [bdq_pkg::MODE_W-1:0]     mode,
	input  logic [bdq_pkg::VALUE_W-1:0]    value_in,
	input  logic [bdq_pkg::POS_W-1:0]      position,
	input  bdq_pkg::cmd_t                  cmd,
	output bdq_pkg::stat_t                 stat,
	output logic [bdq_pkg::STATUS_W-1:0]   status,
	output logic [bdq_pkg::VALUE_W-1:0]    popped_value,
	output logic [bdq_pkg::CNT_W-1:0]      match_count,
	output logic [bdq_pkg::CNT_W-1:0]      occupancy,
	output logic [bdq_pkg::VALUE_W-1:0]    front_value,
	output logic [bdq_pkg::VALUE_W-1:0]    back_value
);
	import bdq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = AW + 1;
	localparam int XW = CW + POS_W;

	logic [DATA_W-1:0] mem [DEPTH];

	mode_t             mode_q;
	logic [DATA_W-1:0] val_q;
	logic [POS_W-1:0]  pos_q;
	logic [AW-1:0]     front_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     k_q;
	logic              cmp_vld_q;
	logic [DATA_W-1:0] rd_data_q;
	status_t           status_q;
	logic [DATA_W-1:0] popped_q;
	logic [CW-1:0]     match_q;
	logic [DATA_W-1:0] front_val_q;
	logic [DATA_W-1:0] back_val_q;

	logic [AW-1:0]     front_dec;
	logic [AW-1:0]     front_inc;
	logic [AW-1:0]     slot_back;
	logic [AW-1:0]     slot_tail;
	logic [AW-1:0]     slot_k;
	logic [AW-1:0]     slot_knext;
	logic [CW-1:0]     k_next;
	logic [AW-1:0]     rd_addr;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic              ins_any;
	logic              rem_any;

	// Ring slot of the element at a given offset from the front; offset stays below DEPTH.
	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base, input logic [CW-1:0] off);
		logic [SW-1:0] sum;
		sum = SW'(base) + SW'(off);
		if (sum >= SW'(DEPTH)) begin
			sum = sum - SW'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	function automatic logic cmd_cmp_hit();
		return cmp_vld_q && (rd_data_q == val_q);
	endfunction

	assign k_next     = k_q + CW'(1);
	assign front_dec  = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
	assign front_inc  = slot_of(front_q, CW'(1));
	assign slot_back  = slot_of(front_q, count_q - CW'(1));
	assign slot_tail  = slot_of(front_q, count_q);
	assign slot_k     = slot_of(front_q, k_q);
	assign slot_knext = slot_of(front_q, k_next);

	assign ins_any = cmd.ins_front | cmd.ins_back;
	assign rem_any = cmd.take_front | cmd.take_back | cmd.drop_front | cmd.dec_count;

	always_comb begin
		case (cmd.rd_sel)
			RD_FRONT: rd_addr = front_q;
			RD_BACK:  rd_addr = slot_back;
			RD_K:     rd_addr = slot_k;
			default:  rd_addr = slot_knext;
		endcase
	end

	always_comb begin
		wr_en   = ins_any | cmd.erase_wr;
		wr_addr = slot_k;
		wr_data = rd_data_q;
		if (cmd.ins_front) begin
			wr_addr = front_dec;
			wr_data = val_q;
		end else if (cmd.ins_back) begin
			wr_addr = slot_tail;
			wr_data = val_q;
		end
	end

	// Store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Latched item fields, walk index and result registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode_t'(mode);
			val_q  <= DATA_W'(value_in);
			pos_q  <= position;
		end
		if (cmd.k_from_pos) begin
			k_q <= CW'(pos_q - POS_W'(1));
		end else if (cmd.k_clear) begin
			k_q <= '0;
		end else if (cmd.erase_wr || cmd.count_rd) begin
			k_q <= k_next;
		end
		if (cmd.cap_popped) begin
			popped_q <= rd_data_q;
		end else if (cmd.load) begin
			popped_q <= '0;
		end
		if (cmd.clr_ends) begin
			front_val_q <= '0;
			back_val_q  <= '0;
		end else begin
			if (cmd.cap_front) begin
				front_val_q <= rd_data_q;
			end
			if (cmd.cap_back) begin
				back_val_q <= rd_data_q;
			end
		end
		if (cmd.set_status) begin
			status_q <= cmd.status_code;
		end else if (cmd.load) begin
			status_q <= ST_OK;
		end
		if (cmd.load) begin
			match_q <= '0;
		end else if (cmd_cmp_hit()) begin
			match_q <= match_q + CW'(1);
		end
	end

	// Ring pointers, occupancy and compare-valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q   <= '0;
			count_q   <= '0;
			cmp_vld_q <= 1'b0;
		end else begin
			cmp_vld_q <= cmd.count_rd;
			if (cmd.ins_front) begin
				front_q <= front_dec;
			end else if (cmd.take_front || cmd.drop_front) begin
				front_q <= front_inc;
			end
			if (ins_any) begin
				count_q <= count_q + CW'(1);
			end else if (rem_any) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign stat.mode       = mode_q;
	assign stat.empty      = (count_q == '0);
	assign stat.full       = (count_q >= CW'(DEPTH));
	assign stat.pos_front  = (pos_q <= POS_W'(1));
	assign stat.pos_beyond = (XW'(pos_q) > XW'(count_q));
	assign stat.erase_more = (k_next < count_q);
	assign stat.count_more = (k_q < count_q);

	assign status       = status_q;
	assign popped_value = VALUE_W'(popped_q);
	assign match_count  = CNT_W'(match_q);
	assign occupancy    = CNT_W'(count_q);
	assign front_value  = VALUE_W'(front_val_q);
	assign back_value   = VALUE_W'(back_val_q);

	`BDQ_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "occupancy above depth")
	`BDQ_ASSERT_SAME(a_no_push_full, ins_any, count_q < CW'(DEPTH), "push while full")
	`BDQ_ASSERT_SAME(a_no_pop_empty, rem_any, count_q != '0, "removal while empty")

endmodule

[hdl/bounded_deque_with_erase_top.sv]
// Top level of the bounded double-ended queue with erase and count.
// Usage:
//   Command channel: drive mode, value_in and position and raise start; the beat
//   is taken at a rising edge where start is high and busy is low.
//   Result channel: done is high for exactly one cycle while status, popped_value,
//   match_count, occupancy, front_value and back_value hold the result beat.
//   The receiver cannot stall; the result must be taken in that cycle.
// Sequencing from accept to done, one item in flight:
//   push, erase beyond occupancy, front erase, unused mode: dispatch, then read
//   the front and back words, or skip the reads when the queue is left empty.
//   pop or erase on an empty queue: dispatch, then finish with no read.
//   pop: dispatch with the read of the popped word, capture it, then read the ends.
//   erase at position p: one read and one write per later element, then read the ends.
//   count: one read per element, then read the ends.
//   A new beat may be taken in the done cycle, so the sustained rate equals the
//   latency. It is set by the single read port of the ring store: each element
//   walked, and the front and back words, take one read each.
// Reset: arst_n clears the front pointer and the occupancy, leaving an empty queue;
//   store contents are not cleared and are only read once written.
module bounded_deque_with_erase_top #(
	parameter int DEPTH    = bdq_pkg::DEPTH_DEF,
	parameter int DATA_W   = bdq_pkg::DATA_W_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [bdq_pkg::MODE_W-1:0]   mode,
	input  logic [bdq_pkg::VALUE_W-1:0]  value_in,
	input  logic [bdq_pkg::POS_W-1:0]    position,
	output logic                         done,
	output logic [bdq_pkg::STATUS_W-1:0] status,
	output logic [bdq_pkg::VALUE_W-1:0]  popped_value,
	output logic [bdq_pkg::CNT_W-1:0]    match_count,
	output logic [bdq_pkg::CNT_W-1:0]    occupancy,
	output logic [bdq_pkg::VALUE_W-1:0]  front_value,
	output logic [bdq_pkg::VALUE_W-1:0]  back_value
);
	import bdq_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// Sequence each operation: dispatch, walk, then read back the queue ends.
	bdq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.stat   (stat),
		.cmd    (cmd)
	);

	// Hold the ring store, pointers and result registers.
	bdq_dpath #(
		.DEPTH  (DEPTH),
		.DATA_W (DATA_W)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.mode         (mode),
		.value_in     (value_in),
		.position     (position),
		.cmd          (cmd),
		.stat         (stat),
		.status       (status),
		.popped_value (popped_value),
		.match_count  (match_count),
		.occupancy    (occupancy),
		.front_value  (front_value),
		.back_value   (back_value)
	);

endmodule

[bench/bounded_deque_with_erase_top_tb.sv]
// Self-checking testbench of the bounded deque: directed rows, then phased random traffic.
module bounded_deque_with_erase_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bdq_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	// Generous bound: every beat a full-depth erase plus the longest command gap,
	// taken several times over.
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int RANDOM_BEATS = 950;
	// Tail wait after the last result: longer than a count over a full store.
	localparam int TAIL_CYCLES = DEPTH + 40;

	// Mode codes that the package leaves unnamed; the block must treat them as no-ops.
	localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

	// Word used to fill the whole store so that a count reaches its top value.
	localparam logic [VALUE_W-1:0] FILL_WORD = 32'hC3C3_3C3C;

	typedef struct packed {
		status_t              status;
		logic [VALUE_W-1:0]   popped;
		logic [CNT_W-1:0]     hits;
		logic [CNT_W-1:0]     occ;
		logic [VALUE_W-1:0]   front;
		logic [VALUE_W-1:0]   back;
	} deque_result_t;

	typedef struct {
		logic [MODE_W-1:0]  op;
		logic [VALUE_W-1:0] word;
		logic [POS_W-1:0]   pos;
		bit                 fixed;
		deque_result_t      want;
	} beat_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic [MODE_W-1:0]     mode = '0;
	logic [VALUE_W-1:0]    value_in = '0;
	logic [POS_W-1:0]      position = '0;
	logic                  busy;
	logic                  done;
	logic [STATUS_W-1:0]   status;
	logic [VALUE_W-1:0]    popped_value;
	logic [CNT_W-1:0]      match_count;
	logic [CNT_W-1:0]      occupancy;
	logic [VALUE_W-1:0]    front_value;
	logic [VALUE_W-1:0]    back_value;

	// Shadow copy of the ring store, the front pointer and the occupancy.
	logic [VALUE_W-1:0]    ring [DEPTH];
	int                    ring_head = 0;
	int                    ring_fill = 0;

	deque_result_t         awaited_results [$];
	beat_row_t             directed_rows [$];
	int                    error_count = 0;
	int                    cycle_count = 0;
	int                    random_beats = 0;
	// When set, commands go back to back with no gap.
	bit                    burst_mode = 1'b0;

	bounded_deque_with_erase_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.value_in     (value_in),
		.position     (position),
		.done         (done),
		.status       (status),
		.popped_value (popped_value),
		.match_count  (match_count),
		.occupancy    (occupancy),
		.front_value  (front_value),
		.back_value   (back_value)
	);

	always begin
		#5ns clk = 1'b1;
		#5ns clk = 1'b0;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Ring slot of the element k places behind the front.
	function automatic int ring_slot(int k);
		return (ring_head + k) % DEPTH;
	endfunction

	// Apply one operation to the shadow deque and work out the result beat.
	task automatic predict_deque_op(input logic [MODE_W-1:0] op, input logic [VALUE_W-1:0] word,
			input logic [POS_W-1:0] pos, output deque_result_t res);
		int k;
		res = '0;
		res.status = ST_OK;
		case (op)
		MODE_PUSH_FRONT: begin
			if (ring_fill >= DEPTH) begin
				res.status = ST_FULL;
			end else begin
				ring_head = (ring_head + DEPTH - 1) % DEPTH;
				ring[ring_head] = word;
				ring_fill++;
			end
		end
		MODE_PUSH_BACK: begin
			if (ring_fill >= DEPTH) begin
				res.status = ST_FULL;
			end else begin
				ring[ring_slot(ring_fill)] = word;
				ring_fill++;
			end
		end
		MODE_POP_FRONT: begin
			if (ring_fill == 0) begin
				res.status = ST_EMPTY;
			end else begin
				res.popped = ring[ring_head];
				ring_head = ring_slot(1);
				ring_fill--;
			end
		end
		MODE_POP_BACK: begin
			if (ring_fill == 0) begin
				res.status = ST_EMPTY;
			end else begin
				res.popped = ring[ring_slot(ring_fill - 1)];
				ring_fill--;
			end
		end
		MODE_ERASE: begin
			if (ring_fill == 0) begin
				res.status = ST_EMPTY;
			end else if (pos <= 1) begin
				ring_head = ring_slot(1);
				ring_fill--;
			end else if (int'(pos) > ring_fill) begin
				res.status = ST_BAD_POS;
			end else begin
				// Close the hole: later elements move one place toward the front.
				for (k = int'(pos) - 1; k + 1 < ring_fill; k++)
					ring[ring_slot(k)] = ring[ring_slot(k + 1)];
				ring_fill--;
			end
		end
		MODE_COUNT: begin
			for (k = 0; k < ring_fill; k++)
				if (ring[ring_slot(k)] == word)
					res.hits++;
		end
		default: ;
		endcase
		res.occ = ring_fill[CNT_W-1:0];
		if (ring_fill != 0) begin
			res.front = ring[ring_head];
			res.back  = ring[ring_slot(ring_fill - 1)];
		end
	endtask

	task automatic add_row(input logic [MODE_W-1:0] op, input logic [VALUE_W-1:0] word,
			input logic [POS_W-1:0] pos);
		beat_row_t row;
		row.op = op;
		row.word = word;
		row.pos = pos;
		row.fixed = 1'b0;
		row.want = '0;
		directed_rows.push_back(row);
	endtask

	// Row whose result is written out by hand instead of taken from the predictor.
	task automatic add_fixed(input logic [MODE_W-1:0] op, input logic [VALUE_W-1:0] word,
			input logic [POS_W-1:0] pos, input status_t st, input logic [VALUE_W-1:0] popped,
			input int hits, input int occ, input logic [VALUE_W-1:0] front,
			input logic [VALUE_W-1:0] back);
		beat_row_t row;
		row.op = op;
		row.word = word;
		row.pos = pos;
		row.fixed = 1'b1;
		row.want.status = st;
		row.want.popped = popped;
		row.want.hits = hits[CNT_W-1:0];
		row.want.occ = occ[CNT_W-1:0];
		row.want.front = front;
		row.want.back = back;
		directed_rows.push_back(row);
	endtask

	// Mostly short gaps, a few long ones; none at all during a burst stretch.
	function automatic int pick_gap();
		int r;
		if (burst_mode)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(0, 2);
		if (r < 92)
			return $urandom_range(3, 8);
		return $urandom_range(10, 40);
	endfunction

	// Words from a small pool half of the time, so counts find hits.
	function automatic logic [VALUE_W-1:0] pick_word();
		case ($urandom_range(0, 7))
		0: return '0;
		1: return '1;
		2: return 32'h5A5A_A5A5;
		3: return FILL_WORD;
		default: return $urandom;
		endcase
	endfunction

	// Positions aimed at the front, the interior, the edge of occupancy and beyond.
	function automatic logic [POS_W-1:0] pick_position();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return POS_W'($urandom_range(0, 1));
		if (r < 55 && ring_fill >= 2)
			return POS_W'($urandom_range(2, ring_fill));
		if (r < 70)
			return POS_W'((ring_fill + 1) % (1 << POS_W));
		return POS_W'($urandom_range(0, (1 << POS_W) - 1));
	endfunction

	function automatic logic [MODE_W-1:0] pick_op(int push_w, int pop_w, int erase_w,
			int count_w);
		int r;
		r = $urandom_range(0, push_w + pop_w + erase_w + count_w + 2);
		if (r < push_w)
			return $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
		r -= push_w;
		if (r < pop_w)
			return $urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT;
		r -= pop_w;
		if (r < erase_w)
			return MODE_ERASE;
		r -= erase_w;
		if (r < count_w)
			return MODE_COUNT;
		return $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
	endfunction

	// Drive one command beat at a falling edge, hold it until taken, then queue the
	// expected result. The fields carry junk while start is low.
	task automatic send_beat(input logic [MODE_W-1:0] op, input logic [VALUE_W-1:0] word,
			input logic [POS_W-1:0] pos, input bit fixed, input deque_result_t want);
		int gap;
		deque_result_t res;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			start    <= 1'b0;
			mode     <= MODE_W'($urandom);
			value_in <= $urandom;
			position <= POS_W'($urandom);
			repeat (gap) @(negedge clk);
		end
		mode     <= op;
		value_in <= word;
		position <= pos;
		start    <= 1'b1;
		// The beat is taken at the first rising edge that sees busy low.
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_deque_op(op, word, pos, res);
		awaited_results.push_back(fixed ? want : res);
	endtask

	task automatic send_random(input logic [MODE_W-1:0] op, input logic [VALUE_W-1:0] word,
			input logic [POS_W-1:0] pos);
		send_beat(op, word, pos, 1'b0, '0);
		random_beats++;
		// Toggle between gapped traffic and back-to-back stretches now and then.
		if (random_beats % 64 == 0)
			burst_mode = !burst_mode;
	endtask

	task automatic send_mixed(input int push_w, input int pop_w, input int erase_w,
			input int count_w);
		logic [MODE_W-1:0] op;
		op = pick_op(push_w, pop_w, erase_w, count_w);
		send_random(op, pick_word(), op == MODE_ERASE ? pick_position() : POS_W'($urandom));
	endtask

	task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
			input logic [VALUE_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			error_count++;
		end
	endtask

	// Result side: every done pulse is one beat; match it against the oldest
	// expectation, field by field.
	always @(posedge clk) begin
		deque_result_t want;
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				$error("result beat with no expectation pending");
				error_count++;
			end else begin
				want = awaited_results[0];
				awaited_results.delete(0);
				check_field("status", VALUE_W'(want.status), VALUE_W'(status));
				check_field("popped_value", want.popped, popped_value);
				check_field("match_count", VALUE_W'(want.hits), VALUE_W'(match_count));
				check_field("occupancy", VALUE_W'(want.occ), VALUE_W'(occupancy));
				check_field("front_value", want.front, front_value);
				check_field("back_value", want.back, back_value);
			end
		end
	end

	initial begin
		int i;
		int n;

		// Empty queue straight out of reset: every failing op and the no-ops.
		add_fixed(MODE_POP_FRONT, '0, '0, ST_EMPTY, '0, 0, 0, '0, '0);
		add_fixed(MODE_POP_BACK, '1, '1, ST_EMPTY, '0, 0, 0, '0, '0);
		add_fixed(MODE_ERASE, '0, 9'd1, ST_EMPTY, '0, 0, 0, '0, '0);
		add_fixed(MODE_COUNT, '1, '0, ST_OK, '0, 0, 0, '0, '0);
		add_fixed(MODE_SPARE_LO, '1, '1, ST_OK, '0, 0, 0, '0, '0);
		add_fixed(MODE_SPARE_HI, '0, '0, ST_OK, '0, 0, 0, '0, '0);
		// First pushes; the push at the front wraps the front pointer below zero.
		add_fixed(MODE_PUSH_BACK, '1, '0, ST_OK, '0, 0, 1, '1, '1);
		add_fixed(MODE_PUSH_FRONT, '0, '1, ST_OK, '0, 0, 2, '0, '1);
		add_row(MODE_PUSH_BACK, 32'h8000_0001, '0);
		add_row(MODE_PUSH_FRONT, 32'h7FFF_FFFE, '0);
		add_row(MODE_PUSH_BACK, '1, '0);
		add_row(MODE_COUNT, '1, '0);
		add_row(MODE_COUNT, '0, '1);
		// Erase beyond occupancy, just past it, the last element, the interior, the front.
		add_row(MODE_ERASE, '0, 9'd511);
		add_row(MODE_ERASE, '0, 9'd6);
		add_row(MODE_ERASE, '0, 9'd5);
		add_row(MODE_ERASE, '0, 9'd2);
		add_row(MODE_ERASE, '0, 9'd0);
		add_row(MODE_POP_BACK, '0, '0);
		add_row(MODE_POP_FRONT, '0, '0);
		add_row(MODE_PUSH_FRONT, 32'h0000_0001, '0);
		add_row(MODE_ERASE, '1, 9'd1);
		add_row(MODE_POP_FRONT, '1, '0);
		add_row(MODE_SPARE_LO, '0, '0);

		// Hold reset, then release it at a falling edge.
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_beat(directed_rows[i].op, directed_rows[i].word, directed_rows[i].pos,
				directed_rows[i].fixed, directed_rows[i].want);

		// Mixed traffic that leans toward growth, so the queue wanders and wraps.
		for (i = 0; i < 200; i++)
			send_mixed(40, 25, 20, 12);

		// Fill the store completely with one word, so a count can hit its top value.
		while (ring_fill < DEPTH)
			send_random($urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT, FILL_WORD,
				POS_W'($urandom));
		send_random(MODE_COUNT, FILL_WORD, '0);
		n = $urandom_range(2, 5);
		for (i = 0; i < n; i++)
			send_random($urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT, $urandom,
				POS_W'($urandom));
		// Erase the very last slot of a full store, then probe the new edge.
		send_random(MODE_ERASE, '0, POS_W'(DEPTH));
		send_random(MODE_ERASE, '0, POS_W'(DEPTH));
		send_random(MODE_ERASE, '0, '1);
		send_random(MODE_PUSH_BACK, $urandom, '0);
		send_random(MODE_PUSH_FRONT, $urandom, '0);
		send_random(MODE_ERASE, '0, POS_W'($urandom_range(2, DEPTH - 1)));

		// Drain with random content mixed in, so long erases shift real data.
		for (i = 0; i < 250; i++)
			send_mixed(15, 45, 30, 10);

		// Balanced traffic until the random budget is spent.
		while (random_beats < RANDOM_BEATS)
			send_mixed(35, 30, 20, 12);

		@(negedge clk);
		start <= 1'b0;

		// Wait out every pending result, then watch for stray ones.
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0 && awaited_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
